// ===== rtl/dpbp_pkg.sv =====
// Package for the depth pixel back-projection core: types, constants, helpers.
package dpbp_pkg;

  localparam int unsigned FRAME_WIDTH  = 320;
  localparam int unsigned FRAME_HEIGHT = 240;

  localparam int unsigned COL_W   = 9;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned GRAY_W  = 8;
  localparam int unsigned CTR_W   = 10;
  localparam int unsigned FOCAL_W = 24;
  localparam int unsigned OFFS_W  = CTR_W + 1;
  localparam int unsigned MUL_A_W = OFFS_W + DEPTH_W;
  localparam int unsigned MUL_B_W = FOCAL_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned FRAC_SHIFT = 25;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = FOCAL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL = 2'd2;

  localparam logic [CTR_W-1:0]   CENTER_X2_RST = 10'd319;
  localparam logic [CTR_W-1:0]   CENTER_Y2_RST = 10'd239;
  localparam logic [FOCAL_W-1:0] INV_FOCAL_RST = 24'd63913;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);

  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth_mm;
    logic [GRAY_W-1:0]         gray_level;
    logic                      frame_start;
  } in_t;

  typedef struct packed {
    logic signed [DEPTH_W-1:0] x_mm;
    logic signed [DEPTH_W-1:0] y_mm;
    logic signed [DEPTH_W-1:0] z_mm;
    logic [GRAY_W-1:0]         gray_out;
    logic [COL_W-1:0]          pixel_col;
    logic [ROW_W-1:0]          pixel_row;
  } out_t;

  // floor(p / 2^FRAC_SHIFT), saturated to 16 bits
  function automatic logic signed [DEPTH_W-1:0] sat_shift(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-FRAC_SHIFT-1:0] q;
    logic                         fits;
    q    = p[PROD_W-1:FRAC_SHIFT];
    fits = (q[PROD_W-FRAC_SHIFT-1:DEPTH_W-1] == '0) ||
           (q[PROD_W-FRAC_SHIFT-1:DEPTH_W-1] == '1);
    if (fits) begin
      sat_shift = q[DEPTH_W-1:0];
    end else if (q[PROD_W-FRAC_SHIFT-1]) begin
      sat_shift = {1'b1, {(DEPTH_W-1){1'b0}}};
    end else begin
      sat_shift = {1'b0, {(DEPTH_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/dpbp_mul.sv =====
// Shared signed multiplier with registered product.
module dpbp_mul (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [dpbp_pkg::MUL_A_W-1:0]    a_i,
  input  logic signed [dpbp_pkg::MUL_B_W-1:0]    b_i,
  output logic signed [dpbp_pkg::PROD_W-1:0]     prod_o
);

  logic signed [dpbp_pkg::PROD_W-1:0] prod_q;
  logic signed [dpbp_pkg::PROD_W-1:0] prod_d;

  assign prod_d = dpbp_pkg::PROD_W'(a_i) * dpbp_pkg::PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/depth_pixel_back_projection_core.sv =====
// Top level of the depth pixel back-projection core.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one depth pixel per
// transfer in raster order; frame_start puts column and row back to zero.
// Output channel (out_valid_o / out_stall_i / out_data_o): one 3-D point per
// pixel with nonzero depth; zero-depth pixels only advance the coordinates.
// Configuration channel (cfg_valid_i / cfg_ready_o): always ready; index 0
// center_x2, 1 center_y2, 2 inv_focal, other indexes are ignored.
// A zero-depth pixel does not stall the input. A nonzero pixel holds off
// the next input transfer through states MX1, MX2, MY1, MY2 and FIN: one
// shared 27x25 multiplier runs offset*depth and then *inv_focal, for x and
// then for y, and FIN loads the output register, from which the point is
// valid on the output. While the receiver stalls, the result holds in the
// output register; the next pixel is still accepted and worked on, and
// only its final load waits for the output register to drain.
// Reset clears the coordinates, the sequencer and output valid and restores
// the register reset values.
module depth_pixel_back_projection_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  dpbp_pkg::in_t                         in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output dpbp_pkg::out_t                        out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dpbp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [dpbp_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MX1  = 3'd1;
  localparam logic [2:0] ST_MX2  = 3'd2;
  localparam logic [2:0] ST_MY1  = 3'd3;
  localparam logic [2:0] ST_MY2  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state_q, state_d;

  logic [dpbp_pkg::CTR_W-1:0]   cx2_q, cy2_q;
  logic [dpbp_pkg::FOCAL_W-1:0] focal_q;

  logic [dpbp_pkg::COL_W-1:0] column_count_q, column_count_d;
  logic [dpbp_pkg::ROW_W-1:0] row_count_q, row_count_d;
  logic [dpbp_pkg::COL_W-1:0] cur_col;
  logic [dpbp_pkg::ROW_W-1:0] cur_row;

  logic signed [dpbp_pkg::DEPTH_W-1:0] depth_q;
  logic [dpbp_pkg::GRAY_W-1:0]         gray_q;
  logic [dpbp_pkg::COL_W-1:0]          pcol_q;
  logic [dpbp_pkg::ROW_W-1:0]          prow_q;
  logic signed [dpbp_pkg::DEPTH_W-1:0] x_q;

  logic                 out_valid_q, out_valid_d;
  dpbp_pkg::out_t       out_q;

  logic in_acc, nonzero, load_out, mul_en, x_en;
  logic signed [dpbp_pkg::OFFS_W-1:0]  offs_x, offs_y;
  logic signed [dpbp_pkg::MUL_A_W-1:0] mul_a;
  logic signed [dpbp_pkg::MUL_B_W-1:0] mul_b;
  logic signed [dpbp_pkg::PROD_W-1:0]  prod;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign nonzero     = (in_data_i.depth_mm != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx2_q   <= dpbp_pkg::CENTER_X2_RST;
      cy2_q   <= dpbp_pkg::CENTER_Y2_RST;
      focal_q <= dpbp_pkg::INV_FOCAL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dpbp_pkg::CFG_CENTER_X2: cx2_q   <= cfg_data_i[dpbp_pkg::CTR_W-1:0];
        dpbp_pkg::CFG_CENTER_Y2: cy2_q   <= cfg_data_i[dpbp_pkg::CTR_W-1:0];
        dpbp_pkg::CFG_INV_FOCAL: focal_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // coordinate tracking
  always_comb begin
    cur_col        = in_data_i.frame_start ? '0 : column_count_q;
    cur_row        = in_data_i.frame_start ? '0 : row_count_q;
    column_count_d = cur_col + 1'b1;
    row_count_d    = cur_row;
    if (cur_col >= dpbp_pkg::COL_LAST) begin
      column_count_d = '0;
      row_count_d    = (cur_row >= dpbp_pkg::ROW_LAST) ? '0 : cur_row + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      row_count_q    <= '0;
    end else if (in_acc) begin
      column_count_q <= column_count_d;
      row_count_q    <= row_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && nonzero) begin
      depth_q <= in_data_i.depth_mm;
      gray_q  <= in_data_i.gray_level;
      pcol_q  <= cur_col;
      prow_q  <= cur_row;
    end
    if (x_en) begin
      x_q <= dpbp_pkg::sat_shift(prod);
    end
  end

  assign offs_x = $signed({1'b0, pcol_q, 1'b0}) - $signed({1'b0, cx2_q});
  assign offs_y = $signed({2'b0, prow_q, 1'b0}) - $signed({1'b0, cy2_q});

  // sequencer and multiplier operand select
  always_comb begin
    state_d  = state_q;
    mul_en   = 1'b0;
    x_en     = 1'b0;
    load_out = 1'b0;
    mul_a    = prod[dpbp_pkg::MUL_A_W-1:0];
    mul_b    = $signed({1'b0, focal_q});
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && nonzero) state_d = ST_MX1;
      end
      ST_MX1: begin
        mul_en  = 1'b1;
        mul_a   = dpbp_pkg::MUL_A_W'(offs_x);
        mul_b   = dpbp_pkg::MUL_B_W'(depth_q);
        state_d = ST_MX2;
      end
      ST_MX2: begin
        mul_en  = 1'b1;
        state_d = ST_MY1;
      end
      ST_MY1: begin
        mul_en  = 1'b1;
        x_en    = 1'b1;
        mul_a   = dpbp_pkg::MUL_A_W'(offs_y);
        mul_b   = dpbp_pkg::MUL_B_W'(depth_q);
        state_d = ST_MY2;
      end
      ST_MY2: begin
        mul_en  = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!(out_valid_q && out_stall_i)) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  dpbp_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign out_valid_d = (out_valid_q && out_stall_i) || load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.x_mm      <= x_q;
      out_q.y_mm      <= dpbp_pkg::sat_shift(prod);
      out_q.z_mm      <= depth_q;
      out_q.gray_out  <= gray_q;
      out_q.pixel_col <= pcol_q;
      out_q.pixel_row <= prow_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/tb_depth_pixel_back_projection_core.sv =====
// Self-checking testbench for depth_pixel_back_projection_core: pixel stream in, points checked.
module tb_depth_pixel_back_projection_core;
  import dpbp_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  class point_scoreboard;
    out_t expected_points[$];
    logic [CTR_W-1:0]   center_x2;
    logic [CTR_W-1:0]   center_y2;
    logic [FOCAL_W-1:0] inv_focal;
    int next_col;
    int next_row;
    int mismatches;
    int points_checked;
    int pixels_seen;

    function new();
      center_x2 = CENTER_X2_RST;
      center_y2 = CENTER_Y2_RST;
      inv_focal = INV_FOCAL_RST;
      next_col = 0;
      next_row = 0;
      mismatches = 0;
      points_checked = 0;
      pixels_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CENTER_X2: center_x2 = data[CTR_W-1:0];
        CFG_CENTER_Y2: center_y2 = data[CTR_W-1:0];
        CFG_INV_FOCAL: inv_focal = data[FOCAL_W-1:0];
        default: ;
      endcase
    endfunction

    // floor((2*coord - centre2) * depth * focal / 2^25), saturated
    function logic signed [DEPTH_W-1:0] project_axis(int coord, logic [CTR_W-1:0] centre2,
                                                     logic signed [DEPTH_W-1:0] depth);
      longint offs;
      longint prod;
      longint q;
      offs = 2 * longint'(coord) - longint'(centre2);
      prod = offs * longint'(depth) * longint'(inv_focal);
      q = prod >>> FRAC_SHIFT;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[DEPTH_W-1:0];
    endfunction

    function void note_pixel(in_t px);
      out_t pt;
      pixels_seen++;
      if (px.frame_start) begin
        next_col = 0;
        next_row = 0;
      end
      if (px.depth_mm != 0) begin
        pt.x_mm      = project_axis(next_col, center_x2, px.depth_mm);
        pt.y_mm      = project_axis(next_row, center_y2, px.depth_mm);
        pt.z_mm      = px.depth_mm;
        pt.gray_out  = px.gray_level;
        pt.pixel_col = next_col[COL_W-1:0];
        pt.pixel_row = next_row[ROW_W-1:0];
        expected_points.insert(expected_points.size(), pt);
      end
      next_col++;
      if (next_col >= FRAME_WIDTH) begin
        next_col = 0;
        next_row++;
        if (next_row >= FRAME_HEIGHT) next_row = 0;
      end
    endfunction

    function void check_point(out_t got);
      out_t exp_pt;
      string bad;
      bad = "";
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point: x=%0d y=%0d z=%0d gray=%0d col=%0d row=%0d",
                   got.x_mm, got.y_mm, got.z_mm, got.gray_out, got.pixel_col, got.pixel_row);
        return;
      end
      exp_pt = expected_points.pop_front();
      points_checked++;
      if (got.x_mm !== exp_pt.x_mm) bad = {bad, " x_mm"};
      if (got.y_mm !== exp_pt.y_mm) bad = {bad, " y_mm"};
      if (got.z_mm !== exp_pt.z_mm) bad = {bad, " z_mm"};
      if (got.gray_out !== exp_pt.gray_out) bad = {bad, " gray_out"};
      if (got.pixel_col !== exp_pt.pixel_col) bad = {bad, " pixel_col"};
      if (got.pixel_row !== exp_pt.pixel_row) bad = {bad, " pixel_row"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("point mismatch on%s", bad);
          $display("  expected x=%0d y=%0d z=%0d gray=%0d col=%0d row=%0d",
                   exp_pt.x_mm, exp_pt.y_mm, exp_pt.z_mm, exp_pt.gray_out,
                   exp_pt.pixel_col, exp_pt.pixel_row);
          $display("  actual   x=%0d y=%0d z=%0d gray=%0d col=%0d row=%0d",
                   got.x_mm, got.y_mm, got.z_mm, got.gray_out, got.pixel_col, got.pixel_row);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  point_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int reg_writes = 0;
  bit hold_trig = 1'b0;
  bit hold_seen = 1'b0;
  int hold_cnt = 0;

  depth_pixel_back_projection_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else if (hold_trig && !hold_seen) begin
      hold_seen   <= 1'b1;
      hold_cnt    <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_point(out_data_o);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_optics(int cx2, int cy2, int focal);
    settle();
    write_reg(CFG_CENTER_X2, CFG_DATA_W'(cx2));
    write_reg(CFG_CENTER_Y2, CFG_DATA_W'(cy2));
    write_reg(CFG_INV_FOCAL, CFG_DATA_W'(focal));
  endtask

  task automatic send_pixel(logic signed [DEPTH_W-1:0] depth, int gray, bit fs);
    in_t px;
    px.depth_mm    = depth;
    px.gray_level  = GRAY_W'(gray);
    px.frame_start = fs;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(px);
  endtask

  function automatic logic signed [DEPTH_W-1:0] rand_depth(int zero_pct);
    int sel;
    sel = $urandom_range(99);
    if (sel < zero_pct) return '0;
    if (sel < zero_pct + 8) begin
      case ($urandom_range(3))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sd1;
        default: return -16'sd1;
      endcase
    end
    if (sel < zero_pct + 35) return DEPTH_W'($urandom);
    return DEPTH_W'($urandom_range(300, 9000));
  endfunction

  // frame-shaped runs of random pixels with occasional stray or missing frame starts
  task automatic run_pixels(int count, int zero_pct);
    int seg_left;
    bit fs;
    seg_left = 0;
    repeat (count) begin
      if (seg_left == 0) begin
        fs = ($urandom_range(9) != 0);
        seg_left = ($urandom_range(3) == 0) ? $urandom_range(300, 700) : $urandom_range(1, 60);
      end else begin
        fs = ($urandom_range(99) < 2);
      end
      seg_left--;
      send_pixel(rand_depth(zero_pct), $urandom_range(255), fs);
    end
  endtask

  function automatic int rand_focal();
    if ($urandom_range(3) == 0) return $urandom_range(0, 24'hffffff);
    return $urandom_range(20000, 200000);
  endfunction

  initial begin
    int c;
    logic signed [DEPTH_W-1:0] d;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, extreme depths and gray levels, zero depth, frame starts
    send_pixel(16'sh7fff, 255, 1'b1);
    send_pixel(16'sh8000, 0, 1'b0);
    send_pixel(16'sd1, 1, 1'b0);
    send_pixel(-16'sd1, 128, 1'b0);
    send_pixel(16'sd0, 77, 1'b0);
    send_pixel(16'sd0, 200, 1'b1);
    send_pixel(16'sd1000, 15, 1'b0);
    send_pixel(-16'sd500, 240, 1'b0);

    // saturation in both directions
    program_optics(0, 1023, 24'hffffff);
    write_reg(CFG_UNUSED, 24'hffffff);
    send_pixel(16'sh7fff, 255, 1'b1);
    send_pixel(16'sh7fff, 1, 1'b0);
    send_pixel(16'sh7fff, 2, 1'b0);
    send_pixel(16'sh8000, 3, 1'b0);
    send_pixel(-16'sd1, 4, 1'b0);
    send_pixel(16'sd5, 5, 1'b0);

    program_optics(1023, 0, 0);
    send_pixel(16'sh8000, 255, 1'b1);
    send_pixel(16'sh7fff, 0, 1'b0);
    send_pixel(16'sd0, 9, 1'b0);

    program_optics(CENTER_X2_RST, CENTER_Y2_RST, INV_FOCAL_RST);
    idle_pct = 0;
    stall_pct = 0;
    run_pixels(200, 20);

    program_optics($urandom_range(1023), $urandom_range(1023), rand_focal());
    idle_pct = 82;
    run_pixels(300, 20);

    program_optics(1023, 0, rand_focal());
    idle_pct = 0;
    stall_pct = 82;
    run_pixels(300, 20);

    program_optics($urandom_range(1023), $urandom_range(1023), 24'hffffff);
    idle_pct = 20;
    stall_pct = 20;
    hold_trig <= 1'b1;
    run_pixels(400, 15);

    program_optics($urandom_range(1023), $urandom_range(1023), 0);
    idle_pct = 0;
    stall_pct = 0;
    run_pixels(150, 20);

    // one row and a bit from a frame start, mostly empty, across the column wrap
    program_optics(CENTER_X2_RST, CENTER_Y2_RST, INV_FOCAL_RST);
    for (int i = 0; i < FRAME_WIDTH + 16; i++) begin
      c = i % FRAME_WIDTH;
      if ((c < 2) || (c >= FRAME_WIDTH - 2))
        d = rand_depth(0);
      else if ($urandom_range(19) == 0)
        d = rand_depth(0);
      else
        d = '0;
      send_pixel(d, $urandom_range(255), i == 0);
    end

    settle();
    if (sb.expected_points.size() != 0) sb.mismatches++;

    $display("covered %0d pixels and %0d points over %0d register writes,",
             sb.pixels_seen, sb.points_checked, reg_writes);
    $display("with saturation, zero focal, stall phases, a long hold-off and a column wrap");
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dpbp_pkg.sv
rtl/dpbp_mul.sv
rtl/depth_pixel_back_projection_core.sv
verif/tb_depth_pixel_back_projection_core.sv
